// ===== design/mmts_pkg.sv =====
// mmts_pkg: shared constants, command/status types and character classes
// for the markup tag stripper. No dependencies.
`timescale 1ns / 1ps

package mmts_pkg;

    // tag store sizing
    localparam int TAG_CHARS = 32;
    localparam int TAG_AW    = $clog2(TAG_CHARS);
    localparam int LEN_W     = $clog2(TAG_CHARS + 1);

    // character codes
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUES  = 8'h3F;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;

    // output operation requested by the controller
    typedef enum logic [2:0] {
        OUT_NONE,
        OUT_EMIT,
        OUT_FLUSH,
        OUT_DIRECT,
        OUT_BARE
    } t_out_op;

    // source of a character that enters the hold stage
    typedef enum logic [1:0] {
        SRC_CHAR,
        SRC_LT,
        SRC_BODY,
        SRC_GT
    } t_emit_src;

    // controller to datapath commands
    typedef struct packed {
        logic      accept;
        t_out_op   out_op;
        t_emit_src src;
        logic      last;
        logic      end_text;
        logic      idx_inc;
        logic      idx_clr;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic show;
        logic in_lt;
        logic in_gt;
        logic in_last;
        logic in_tag;
        logic wt;
        logic held_valid;
        logic out_free;
        logic idx_done;
        logic last;
    } t_stat;

    // characters that trigger a take-back after a removed tag
    function automatic logic follows_removal(input logic [7:0] c);
        return (c inside {CH_SP, CH_COMMA, CH_SEMI, CH_DOT, CH_QUES,
                          CH_EXCL, CH_RPAR, CH_APOS, CH_QUOT});
    endfunction

endpackage

// ===== design/mmts_if.sv =====
// mmts_in_if / mmts_out_if: valid/ready item channels of the tag stripper.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface mmts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       in_last;

    modport source (output valid, output in_char, output in_last, input ready);
    modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface mmts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       has_char;
    logic       out_last;

    modport source (output valid, output out_char, output has_char, output out_last,
                    input ready);
    modport sink   (input valid, input out_char, input has_char, input out_last,
                    output ready);
endinterface

// ===== design/mmts_ctrl.sv =====
// mmts_ctrl: sequencing state machine of the tag stripper.
// Depends on mmts_pkg; drives t_cmd to mmts_dp and reads t_stat back.
`timescale 1ns / 1ps

module mmts_ctrl import mmts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PASS,
        S_CHAR,
        S_LT,
        S_BODY,
        S_GT,
        S_FINAL
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;
    t_cmd   cmd;
    logic   can_emit;
    t_state acc_end;
    t_state item_end;

    // an emit needs the output slot only when a held character is pushed out
    assign can_emit = !i_stat.held_valid || i_stat.out_free;
    assign acc_end  = i_stat.in_last ? S_FINAL : S_IDLE;
    assign item_end = i_stat.last ? S_FINAL : S_IDLE;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        cmd.accept   = 1'b0;
        cmd.out_op   = OUT_NONE;
        cmd.src      = SRC_CHAR;
        cmd.last     = 1'b0;
        cmd.end_text = 1'b0;
        cmd.idx_inc  = 1'b0;
        cmd.idx_clr  = 1'b0;
        case (r_state)
            S_IDLE: begin
                cmd.idx_clr = 1'b1;
                if (i_in_valid && r_in_ready) begin
                    cmd.accept = 1'b1;
                    if (i_stat.show) begin
                        n_state = S_PASS;
                    end else if (i_stat.in_lt) begin
                        n_state = acc_end;
                    end else if (i_stat.in_gt) begin
                        n_state = i_stat.wt ? acc_end : S_LT;
                    end else if (i_stat.in_tag) begin
                        n_state = acc_end;
                    end else begin
                        n_state = S_CHAR;
                    end
                end
            end
            S_PASS: begin
                if (i_stat.out_free) begin
                    if (i_stat.held_valid) begin
                        cmd.out_op = OUT_FLUSH;
                    end else begin
                        cmd.out_op   = OUT_DIRECT;
                        cmd.last     = i_stat.last;
                        cmd.end_text = i_stat.last;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_CHAR: begin
                if (can_emit) begin
                    cmd.out_op = OUT_EMIT;
                    cmd.src    = SRC_CHAR;
                    n_state    = item_end;
                end
            end
            S_LT: begin
                if (can_emit) begin
                    cmd.out_op = OUT_EMIT;
                    cmd.src    = SRC_LT;
                    n_state    = S_BODY;
                end
            end
            S_BODY: begin
                if (i_stat.idx_done) begin
                    n_state = S_GT;
                end else if (can_emit) begin
                    cmd.out_op  = OUT_EMIT;
                    cmd.src     = SRC_BODY;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_GT: begin
                if (can_emit) begin
                    cmd.out_op = OUT_EMIT;
                    cmd.src    = SRC_GT;
                    n_state    = item_end;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    cmd.out_op   = i_stat.held_valid ? OUT_FLUSH : OUT_BARE;
                    cmd.last     = 1'b1;
                    cmd.end_text = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = cmd;

endmodule

// ===== design/mmts_dp.sv =====
// mmts_dp: tag store, hold stage, text state and output register of the
// tag stripper. Depends on mmts_pkg; commanded by mmts_ctrl.
`timescale 1ns / 1ps

module mmts_dp import mmts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic [7:0] i_in_char,
    input  logic       i_in_last,
    input  t_cmd       i_cmd,
    input  logic       i_out_ready,
    output t_stat      o_stat,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_has_char,
    output logic       o_out_last
);

    logic [7:0]     mem [TAG_CHARS];
    logic [7:0]     r_rd_data;
    logic           r_show;
    logic [7:0]     r_c;
    logic           r_last;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic           r_in_tag;
    logic           r_lws;
    logic           r_check;
    logic [7:0]     r_held_char;
    logic           r_held_valid;
    logic [7:0]     r_c0, r_c1;
    logic           r_out_valid;
    logic [7:0]     r_out_char;
    logic           r_out_has;
    logic           r_out_last;

    logic           out_free;
    logic           in_lt, in_gt;
    logic           strip_acc;
    logic           tag_wr;
    logic           wt;
    logic           emit;
    logic [7:0]     emit_val;
    logic           push;
    logic [7:0]     push_char;
    logic           push_has;

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_lt     = (i_in_char == CH_LT);
    assign in_gt     = (i_in_char == CH_GT);
    assign strip_acc = i_cmd.accept && !r_show;
    assign tag_wr    = strip_acc && !in_lt && !in_gt && r_in_tag
                       && (r_len < LEN_W'(TAG_CHARS));
    assign wt        = (r_len >= LEN_W'(2)) && (r_c0 == CH_W) && (r_c1 == CH_T);
    assign emit      = (i_cmd.out_op == OUT_EMIT);

    // character entering the hold stage
    always_comb begin
        case (i_cmd.src)
            SRC_CHAR: emit_val = r_c;
            SRC_LT:   emit_val = CH_LT;
            SRC_BODY: emit_val = r_rd_data;
            SRC_GT:   emit_val = CH_GT;
            default:  emit_val = r_c;
        endcase
    end

    // what goes to the output register
    always_comb begin
        push      = 1'b0;
        push_char = r_held_char;
        push_has  = 1'b1;
        case (i_cmd.out_op)
            OUT_EMIT:   push = r_held_valid;
            OUT_FLUSH:  push = 1'b1;
            OUT_DIRECT: begin
                push      = 1'b1;
                push_char = r_c;
            end
            OUT_BARE: begin
                push      = 1'b1;
                push_char = 8'h00;
                push_has  = 1'b0;
            end
            default:    push = 1'b0;
        endcase
    end

    // replay index
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + LEN_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show       <= 1'b0;
            r_len        <= '0;
            r_idx        <= '0;
            r_in_tag     <= 1'b0;
            r_lws        <= 1'b0;
            r_check      <= 1'b0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_show <= i_cfg_wdata;
            end
            r_idx <= n_idx;
            // output register
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // hold stage valid
            if (strip_acc) begin
                if (r_check && follows_removal(i_in_char) && r_lws) begin
                    r_held_valid <= 1'b0;
                end
            end else if (emit) begin
                r_held_valid <= 1'b1;
            end else if (i_cmd.out_op == OUT_FLUSH) begin
                r_held_valid <= 1'b0;
            end
            // tag parsing
            if (i_cmd.accept) begin
                if (r_show) begin
                    r_check <= 1'b0;
                end else begin
                    r_check <= in_gt && wt;
                    if (in_lt) begin
                        r_in_tag <= 1'b1;
                        r_len    <= '0;
                    end else if (in_gt) begin
                        r_in_tag <= 1'b0;
                    end else if (tag_wr) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                end
            end
            if (emit && (i_cmd.src == SRC_CHAR)) begin
                r_lws <= (r_c == CH_SP);
            end
            // end of text returns to a fresh start
            if (i_cmd.end_text) begin
                r_len    <= '0;
                r_in_tag <= 1'b0;
                r_lws    <= 1'b0;
                r_check  <= 1'b0;
            end
        end
    end

    // payload registers and tag store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_c    <= i_in_char;
            r_last <= i_in_last;
        end
        if (tag_wr) begin
            mem[r_len[TAG_AW-1:0]] <= i_in_char;
            if (r_len == LEN_W'(0)) begin
                r_c0 <= i_in_char;
            end
            if (r_len == LEN_W'(1)) begin
                r_c1 <= i_in_char;
            end
        end
        r_rd_data <= mem[n_idx[TAG_AW-1:0]];
        if (emit) begin
            r_held_char <= emit_val;
        end
        if (push) begin
            r_out_char <= push_char;
            r_out_has  <= push_has;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_stat.show       = r_show;
    assign o_stat.in_lt      = in_lt;
    assign o_stat.in_gt      = in_gt;
    assign o_stat.in_last    = i_in_last;
    assign o_stat.in_tag     = r_in_tag;
    assign o_stat.wt         = wt;
    assign o_stat.held_valid = r_held_valid;
    assign o_stat.out_free   = out_free;
    assign o_stat.idx_done   = (r_idx == r_len);
    assign o_stat.last       = r_last;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_has_char  = r_out_has;
    assign o_out_last  = r_out_last;

    // a result is only written into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free) else $error("push into occupied output register");

    // an emit always leaves a character in the hold stage
    a_emit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_held_valid) else $error("hold stage empty after emit");

    // replay never reads past the stored tag text
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.idx_inc |-> (r_idx < r_len)) else $error("replay index overrun");

endmodule

// ===== design/markup_morph_tag_stripper.sv =====
// Top level of the markup tag stripper: strips tags that begin with "WT" from
// a character stream, one item at a time. In strip mode a plain character is
// accepted, then moved into the hold stage; characters inside a tag, '<' and
// the '>' of a removed tag are only accepted; a kept tag is replayed as '<',
// the stored characters one entry a cycle from the tag store while the output
// does not stall, and '>'; the end of a text adds a final flush. In pass mode
// a character goes straight out, after a held character is released first.
// The output register stalls the sequencer only when a result must leave while
// the previous one has not been taken. In strip mode output lags by one
// character, held back for a possible take-back after a removed tag.
// Depends on mmts_pkg, mmts_if, mmts_ctrl and mmts_dp.
`timescale 1ns / 1ps

module markup_morph_tag_stripper import mmts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    mmts_in_if.sink   i_in,
    mmts_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // sequencer
    mmts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // datapath
    mmts_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_char   (i_in.in_char),
        .i_in_last   (i_in.in_last),
        .i_cmd       (cmd),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.out_char),
        .o_has_char  (o_out.has_char),
        .o_out_last  (o_out.out_last)
    );

    assign i_in.ready = in_ready;

endmodule
